// File: sv/frlr_pkg.sv
// Shared types and constants of the fractional linear resampler.
`default_nettype none

package frlr_pkg;

  localparam int unsigned PHASE_W    = 21;
  localparam int unsigned STEP_W     = 20;
  localparam int unsigned OUT_W      = 16;
  localparam logic [STEP_W-1:0] STEP_RESET = 20'd73881;
  localparam int SAT_MAX = 32767;
  localparam int SAT_MIN = -32768;

  // One back-end operation; the final op of every item shifts the bracket.
  typedef struct packed {
    logic               emit;
    logic               last;
    logic               mix;
    logic [PHASE_W-2:0] frac;
  } op_t;

endpackage

`default_nettype wire

// File: sv/frlr_fifo.sv
// Small register queue between the sequencer front end and the datapath.
`default_nettype none

module frlr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic [WIDTH-1:0]      rdata_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// File: sv/frlr_front.sv
// Front end: takes input transactions, tracks phase and expands each into ops.
`default_nettype none

module frlr_front #(
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [frlr_pkg::STEP_W-1:0]   cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0] chip_sample_i,
  input  wire logic signed [SAMPLE_BITS-1:0] bank_two_sample_i,
  input  wire logic                          mix_both_i,
  input  wire logic                          q_full_i,
  output logic                               q_push_o,
  output frlr_pkg::op_t                      q_op_o,
  output logic signed [SAMPLE_BITS-1:0]      q_s1_o,
  output logic signed [SAMPLE_BITS-1:0]      q_s2_o
);

  import frlr_pkg::*;

  localparam logic [PHASE_W-1:0] PhaseOne = PHASE_W'(1) << FRAC_BITS;
  localparam logic [STEP_W-1:0]  StepMin  = STEP_W'(1) << (FRAC_BITS - 4);

  logic                          cur_valid_q, cur_valid_d;
  logic signed [SAMPLE_BITS-1:0] cur_s1_q, cur_s2_q;
  logic                          cur_mix_q;
  logic [PHASE_W-1:0]            phase_q, phase_d;
  logic [STEP_W-1:0]             step_q;
  logic [STEP_W-1:0]             step_eff;
  logic [PHASE_W-1:0]            phase_adv;
  logic                          emit, last, done, accept;

  assign step_eff  = (step_q < StepMin) ? StepMin : step_q;
  assign phase_adv = phase_q + PHASE_W'(step_eff);
  assign emit      = (phase_q < PhaseOne);
  assign last      = emit && (phase_adv >= PhaseOne);
  assign q_push_o  = cur_valid_q && !q_full_i;
  assign done      = q_push_o && (!emit || last);
  assign in_stall_o = cur_valid_q && !done;
  assign accept    = in_valid_i && !in_stall_o;

  assign q_op_o.emit = emit;
  assign q_op_o.last = last;
  assign q_op_o.mix  = cur_mix_q;
  assign q_op_o.frac = phase_q[PHASE_W-2:0];
  assign q_s1_o      = cur_s1_q;
  assign q_s2_o      = cur_s2_q;

  always_comb begin
    phase_d = phase_q;
    if (q_push_o) begin
      if (!emit) begin
        phase_d = phase_q - PhaseOne;
      end else if (last) begin
        phase_d = phase_adv - PhaseOne;
      end else begin
        phase_d = phase_adv;
      end
    end
    if (accept) begin
      cur_valid_d = 1'b1;
    end else if (done) begin
      cur_valid_d = 1'b0;
    end else begin
      cur_valid_d = cur_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      phase_q     <= '0;
      step_q      <= STEP_RESET;
    end else begin
      cur_valid_q <= cur_valid_d;
      phase_q     <= phase_d;
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_s1_q  <= chip_sample_i;
      cur_s2_q  <= bank_two_sample_i;
      cur_mix_q <= mix_both_i;
    end
  end

endmodule

`default_nettype wire

// File: sv/frlr_back.sv
// Back end: bracket registers, two-stage interpolate/average/saturate datapath.
`default_nettype none

module frlr_back #(
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_empty_i,
  output logic                               q_pop_o,
  input  wire frlr_pkg::op_t                 q_op_i,
  input  wire logic signed [SAMPLE_BITS-1:0] q_s1_i,
  input  wire logic signed [SAMPLE_BITS-1:0] q_s2_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [frlr_pkg::OUT_W-1:0]  out_sample_o,
  output logic                               last_of_run_o
);

  import frlr_pkg::*;

  localparam int unsigned DW = SAMPLE_BITS + 1;
  localparam int unsigned PW = SAMPLE_BITS + FRAC_BITS + 2;
  localparam int unsigned VW = SAMPLE_BITS + 3;

  logic signed [SAMPLE_BITS-1:0] old1_q, new1_q, old2_q, new2_q;

  logic                          a_valid_q, a_valid_d;
  logic signed [PW-1:0]          prod1_q, prod2_q;
  logic signed [SAMPLE_BITS-1:0] base1_q, base2_q;
  logic                          a_mix_q, a_last_q;

  logic                          o_valid_q, o_valid_d;
  logic signed [OUT_W-1:0]       o_sample_q;
  logic                          o_last_q;

  logic                          adv_b, shift;
  logic signed [DW-1:0]          diff1, diff2;
  logic signed [FRAC_BITS:0]     frac_s;
  logic signed [PW-1:0]          prod1, prod2;
  logic signed [VW-1:0]          q1, q2, v1, v2, sum, rnd, sum_r, avg, sel;
  logic signed [OUT_W-1:0]       sat;

  assign adv_b   = !o_valid_q || !out_stall_i;
  assign q_pop_o = !q_empty_i && (!a_valid_q || adv_b);
  assign shift   = q_pop_o && (!q_op_i.emit || q_op_i.last);

  // Stage A: weighted differences of both banks
  assign diff1  = DW'(new1_q) - DW'(old1_q);
  assign diff2  = DW'(new2_q) - DW'(old2_q);
  assign frac_s = {1'b0, q_op_i.frac[FRAC_BITS-1:0]};
  assign prod1  = PW'(diff1) * PW'(frac_s);
  assign prod2  = PW'(diff2) * PW'(frac_s);

  // Stage B: floor shift, add base, average toward zero (mix only), saturate
  always_comb begin
    q1    = VW'(prod1_q >>> FRAC_BITS);
    q2    = VW'(prod2_q >>> FRAC_BITS);
    v1    = VW'(base1_q) + q1;
    v2    = VW'(base2_q) + q2;
    sum   = v1 + v2;
    rnd   = {{(VW-1){1'b0}}, sum[VW-1] & sum[0]};
    sum_r = sum + rnd;
    avg   = sum_r >>> 1;
    sel   = a_mix_q ? avg : v1;
    priority if (sel > VW'(SAT_MAX)) begin
      sat = OUT_W'(SAT_MAX);
    end else if (sel < VW'(SAT_MIN)) begin
      sat = OUT_W'(SAT_MIN);
    end else begin
      sat = sel[OUT_W-1:0];
    end
  end

  always_comb begin
    a_valid_d = a_valid_q;
    if (q_pop_o) begin
      a_valid_d = q_op_i.emit;
    end else if (adv_b) begin
      a_valid_d = 1'b0;
    end
    o_valid_d = adv_b ? a_valid_q : o_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
      old1_q    <= '0;
      new1_q    <= '0;
      old2_q    <= '0;
      new2_q    <= '0;
    end else begin
      a_valid_q <= a_valid_d;
      o_valid_q <= o_valid_d;
      if (shift) begin
        old1_q <= new1_q;
        new1_q <= q_s1_i;
        if (q_op_i.mix) begin
          old2_q <= new2_q;
          new2_q <= q_s2_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_op_i.emit) begin
      prod1_q  <= prod1;
      prod2_q  <= prod2;
      base1_q  <= old1_q;
      base2_q  <= old2_q;
      a_mix_q  <= q_op_i.mix;
      a_last_q <= q_op_i.last;
    end
    if (adv_b && a_valid_q) begin
      o_sample_q <= sat;
      o_last_q   <= a_last_q;
    end
  end

  assign out_valid_o   = o_valid_q;
  assign out_sample_o  = o_sample_q;
  assign last_of_run_o = o_last_q;

endmodule

`default_nettype wire

// File: sv/fractional_linear_resampler.sv
// Top level: fractional linear resampler, front sequencer + op queue + datapath.
// First result path: front register, op queue, stage A register, output register.
// Throughput: front issues one op per cycle if the queue has room; a transaction
//   of n results takes max(n,1) ops; results leave one per cycle if not stalled.
// Reset: phase, bracket samples and queue clear; phase_step returns to 73881.
`default_nettype none

module fractional_linear_resampler #(
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [frlr_pkg::STEP_W-1:0]   cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0] chip_sample_i,
  input  wire logic signed [SAMPLE_BITS-1:0] bank_two_sample_i,
  input  wire logic                          mix_both_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [frlr_pkg::OUT_W-1:0]  out_sample_o,
  output logic                               last_of_run_o
);

  import frlr_pkg::*;

  localparam int unsigned QW = $bits(op_t) + 2 * SAMPLE_BITS;

  logic                          q_push, q_pop, q_full, q_empty;
  op_t                           push_op, pop_op;
  logic signed [SAMPLE_BITS-1:0] push_s1, push_s2, pop_s1, pop_s2;
  logic [QW-1:0]                 q_wdata, q_rdata;

  assign q_wdata = {push_op, push_s1, push_s2};
  assign pop_op  = q_rdata[QW-1 -: $bits(op_t)];
  assign pop_s1  = q_rdata[2*SAMPLE_BITS-1 -: SAMPLE_BITS];
  assign pop_s2  = q_rdata[SAMPLE_BITS-1:0];

  frlr_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .chip_sample_i    (chip_sample_i),
    .bank_two_sample_i(bank_two_sample_i),
    .mix_both_i       (mix_both_i),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_op_o           (push_op),
    .q_s1_o           (push_s1),
    .q_s2_o           (push_s2)
  );

  frlr_fifo #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i(q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .rdata_o(q_rdata)
  );

  frlr_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_pop),
    .q_op_i       (pop_op),
    .q_s1_i       (pop_s1),
    .q_s2_i       (pop_s2),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_sample_o (out_sample_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule

`default_nettype wire

// File: sv/frlr_checker.sv
// Port-level assertions for the fractional linear resampler, bound to the top.
`default_nettype none

module frlr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [15:0] out_sample_o,
  input wire logic        last_of_run_o
);

  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_sample_o) && $stable(last_of_run_o))
    else $error("stalled result changed");

  a_no_out_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

  a_ready_after_reset: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !in_stall_o)
    else $error("input stalled right after reset");

endmodule

bind fractional_linear_resampler frlr_checker u_frlr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_sample_o (out_sample_o),
  .last_of_run_o(last_of_run_o)
);

`default_nettype wire
